// ===== design/assert_macros.svh =====
// Assertion macros shared by the parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hidrd_pkg.sv =====
// ----------------------------------------------------------------------------
// hidrd_pkg
// Types and constants of the HID report descriptor parser.
// ----------------------------------------------------------------------------
package hidrd_pkg;

  localparam int USAGE_DEPTH = 16;
  localparam int MAX_FIELDS  = 64;
  localparam int UW          = $clog2(USAGE_DEPTH);
  localparam int FILL_W      = $clog2(USAGE_DEPTH + 1);

  localparam logic [7:0] TAG_MASK    = 8'hFC;
  localparam logic [7:0] TAG_END_COL = 8'hC0;
  localparam logic [7:0] TAG_COL     = 8'hA0;
  localparam logic [7:0] TAG_INPUT   = 8'h80;
  localparam logic [7:0] TAG_COUNT   = 8'h94;
  localparam logic [7:0] TAG_SIZE    = 8'h74;
  localparam logic [7:0] TAG_PAGE    = 8'h04;
  localparam logic [7:0] TAG_LMAX    = 8'h24;
  localparam logic [7:0] TAG_LMIN    = 8'h14;
  localparam logic [7:0] TAG_UMAX    = 8'h28;
  localparam logic [7:0] TAG_UMIN    = 8'h18;
  localparam logic [7:0] TAG_USAGE   = 8'h08;

  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_MISSING = 3'd1;
  localparam logic [2:0] ERR_UNPAIR  = 3'd2;
  localparam logic [2:0] ERR_BOTH    = 3'd3;
  localparam logic [2:0] ERR_TAG     = 3'd4;
  localparam logic [2:0] ERR_WIDE    = 3'd5;
  localparam logic [2:0] ERR_FULL    = 3'd6;
  localparam logic [2:0] ERR_OVF     = 3'd7;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       first;
  } in_word_t;

  typedef struct packed {
    logic [15:0] field_bit_offset;
    logic [5:0]  field_bit_size;
    logic [15:0] field_page;
    logic [15:0] usage_id;
    logic        last;
    logic [2:0]  error_code;
  } out_word_t;

  // one completed item, handed from front to back
  typedef struct packed {
    logic        first;
    logic [7:0]  tag;
    logic [2:0]  size;
    logic [31:0] data;
  } item_t;

endpackage

// ===== design/hid_report_descriptor_parser_top.sv =====
// ----------------------------------------------------------------------------
// hid_report_descriptor_parser_top
// HID report descriptor parser, short items, one byte per word.
// ----------------------------------------------------------------------------
// channel  direction  payload
// in_      input      in_word_t  (desc_byte, first)
// out_     output     out_word_t (field descriptor or error code)
//
// One byte per cycle while no Input item runs; a complete item enters a
// one-entry queue to the back end. An Input item is checked first and its
// fields (up to the report count) are then emitted by the back-end
// sequencer. Synchronous active-low reset clears all parse state.
// Output stalls hold the back end, and the queue then stalls byte intake.
module hid_report_descriptor_parser_top import hidrd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic  item_valid, item_ready;
  item_t item;

  hidrd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .item_valid(item_valid), .item_ready(item_ready), .item(item)
  );

  hidrd_back u_back (
    .clk(clk), .rst_n(rst_n), .item_valid(item_valid), .item_ready(item_ready),
    .item(item), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

// ===== design/hidrd_front.sv =====
// ----------------------------------------------------------------------------
// hidrd_front
// Assembles prefix and data bytes into complete items.
// ----------------------------------------------------------------------------
module hidrd_front import hidrd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     item_valid,
  input  logic     item_ready,
  output item_t    item
);

  logic [2:0]  left_r, left_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [2:0]  size_r, size_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        first_r, first_nxt;
  logic        vld_r, vld_nxt;
  item_t       item_r, item_nxt;
  logic [1:0]  pos;
  logic [2:0]  left_eff;
  logic        acc;

  // one-entry queue toward the back end
  assign in_ready   = !vld_r || item_ready;
  assign acc        = in_valid && in_ready;
  assign item_valid = vld_r;
  assign item       = item_r;
  assign left_eff   = in_data.first ? 3'd0 : left_r;
  assign pos        = 2'(size_r - left_r);

  always_comb begin
    left_nxt  = left_r;
    tag_nxt   = tag_r;
    size_nxt  = size_r;
    acc_nxt   = acc_r;
    first_nxt = first_r;
    vld_nxt   = vld_r && !item_ready;
    item_nxt  = item_r;
    if (acc) begin
      if (in_data.first) first_nxt = 1'b1;
      if (left_eff == 3'd0) begin
        tag_nxt  = in_data.desc_byte & TAG_MASK;
        size_nxt = (in_data.desc_byte[1:0] == 2'd3) ? 3'd4 : {1'b0, in_data.desc_byte[1:0]};
        acc_nxt  = '0;
        if (in_data.desc_byte[1:0] == 2'd0) begin
          vld_nxt   = 1'b1;
          item_nxt  = '{first: first_nxt, tag: tag_nxt, size: 3'd0, data: 32'd0};
          first_nxt = 1'b0;
        end else begin
          left_nxt = size_nxt;
        end
      end else begin
        acc_nxt  = acc_r | (32'(in_data.desc_byte) << {pos, 3'b000});
        left_nxt = left_r - 3'd1;
        if (left_r == 3'd1) begin
          vld_nxt   = 1'b1;
          item_nxt  = '{first: first_nxt, tag: tag_r, size: size_r, data: acc_nxt};
          first_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      tag_r   <= '0;
      size_r  <= '0;
      acc_r   <= '0;
      first_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      left_r  <= left_nxt;
      tag_r   <= tag_nxt;
      size_r  <= size_nxt;
      acc_r   <= acc_nxt;
      first_r <= first_nxt;
      vld_r   <= vld_nxt;
    end
    item_r <= item_nxt;
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_left_range, clk, rst_n, 1'b1, left_r <= size_r, "bytes left exceeds size")
  `ASSERT_NEXT(a_hold, clk, rst_n, vld_r && !item_ready, vld_r && $stable(item_r),
               "queued item changed while stalled")
  `ASSERT_IMPL(a_ready_free, clk, rst_n, !vld_r, in_ready, "front stalled with empty queue")

endmodule

// ===== design/hidrd_back.sv =====
// ----------------------------------------------------------------------------
// hidrd_back
// Executes items: updates global and local state, emits field and error words.
// ----------------------------------------------------------------------------
module hidrd_back import hidrd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  output logic      item_ready,
  input  item_t     item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT} state_t;

  state_t      state_r, state_nxt;
  logic [15:0] count_r, count_nxt;
  logic [5:0]  sz_r, sz_nxt;
  logic [15:0] page_r, page_nxt;
  logic [3:0]  pf_r, pf_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [15:0] min_r, min_nxt, max_r, max_nxt;
  logic [15:0] off_r, off_nxt;
  logic        err_r, err_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic        ov_r, ov_nxt;
  out_word_t   od_r, od_nxt;
  logic [15:0] mem [USAGE_DEPTH];
  logic [15:0] rd_r;
  logic        we;
  logic [UW-1:0] wa, ra;
  logic [FILL_W-1:0] fill_e;
  logic [3:0]  pf_e;
  logic [21:0] total;
  logic [22:0] sum;
  logic [15:0] rid;
  logic        take, busy;

  assign busy       = (state_r != S_IDLE) || (ov_r && !out_ready);
  assign item_ready = !busy;
  assign take       = item_valid && item_ready;
  assign fill_e     = item.first ? '0 : fill_r;
  assign pf_e       = item.first ? 4'd0 : pf_r;
  assign total      = 22'(sz_r) * 22'(count_r);
  assign sum        = {7'd0, off_r} + {1'b0, total};
  assign out_valid  = ov_r;
  assign out_data   = od_r;
  assign ra         = (idx_nxt < 7'(fill_r)) ? UW'(idx_nxt) : UW'(fill_r - FILL_W'(1));
  assign wa         = UW'(fill_e);
  assign we         = take && !(err_r && !item.first) && item.tag == TAG_USAGE
                      && item.size != 3'd4 && fill_e < FILL_W'(USAGE_DEPTH);
  assign rid        = (16'(min_r + 16'(idx_r)) > max_r) ? max_r : 16'(min_r + 16'(idx_r));

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= item.data[15:0];
    rd_r <= mem[ra];
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r; sz_nxt = sz_r; page_nxt = page_r; pf_nxt = pf_r;
    fill_nxt = fill_r; min_nxt = min_r; max_nxt = max_r; off_nxt = off_r;
    err_nxt = err_r; idx_nxt = idx_r;
    ov_nxt = ov_r && !out_ready; od_nxt = od_r;
    if (take) begin
      if (item.first) begin
        count_nxt = '0; sz_nxt = '0; page_nxt = '0; pf_nxt = '0; fill_nxt = '0;
        min_nxt = '0; max_nxt = '0; off_nxt = '0; err_nxt = 1'b0;
      end
      if (!err_nxt) begin
        od_nxt = '0;
        od_nxt.last = 1'b1;
        case (item.tag)
          TAG_END_COL, TAG_LMAX, TAG_LMIN: ;
          TAG_COL: begin
            fill_nxt = '0; pf_nxt = pf_e & 4'b0011; min_nxt = '0; max_nxt = '0;
          end
          TAG_INPUT: state_nxt = S_READ;
          TAG_COUNT: begin
            if (item.data[31:16] != 16'd0) begin
              od_nxt.error_code = ERR_OVF; ov_nxt = 1'b1; err_nxt = 1'b1;
            end else begin
              count_nxt = item.data[15:0]; pf_nxt = pf_e | 4'b0001;
            end
          end
          TAG_SIZE: begin
            if (item.data > 32'd32) begin
              od_nxt.error_code = ERR_OVF; ov_nxt = 1'b1; err_nxt = 1'b1;
            end else begin
              sz_nxt = item.data[5:0]; pf_nxt = pf_e | 4'b0010;
            end
          end
          TAG_PAGE: page_nxt = item.data[15:0];
          TAG_UMAX, TAG_UMIN, TAG_USAGE: begin
            if (item.size == 3'd4) begin
              od_nxt.error_code = ERR_WIDE; ov_nxt = 1'b1; err_nxt = 1'b1;
            end else if (item.tag == TAG_UMAX) begin
              max_nxt = item.data[15:0]; pf_nxt = pf_e | 4'b1000;
            end else if (item.tag == TAG_UMIN) begin
              min_nxt = item.data[15:0]; pf_nxt = pf_e | 4'b0100;
            end else if (fill_e >= FILL_W'(USAGE_DEPTH)) begin
              od_nxt.error_code = ERR_FULL; ov_nxt = 1'b1; err_nxt = 1'b1;
            end else begin
              fill_nxt = fill_e + FILL_W'(1);
            end
          end
          default: begin
            od_nxt.error_code = ERR_TAG; ov_nxt = 1'b1; err_nxt = 1'b1;
          end
        endcase
      end
    end else begin
      case (state_r)
        S_READ: begin
          // checks of the Input item, in priority order
          od_nxt = '0;
          od_nxt.last = 1'b1;
          idx_nxt = '0;
          state_nxt = S_IDLE;
          if (!pf_r[0] || !pf_r[1]) begin
            od_nxt.error_code = ERR_MISSING; ov_nxt = 1'b1; err_nxt = 1'b1;
          end else if (pf_r[2] != pf_r[3]) begin
            od_nxt.error_code = ERR_UNPAIR; ov_nxt = 1'b1; err_nxt = 1'b1;
          end else if (fill_r != '0 && pf_r[2]) begin
            od_nxt.error_code = ERR_BOTH; ov_nxt = 1'b1; err_nxt = 1'b1;
          end else if (sum > 23'hFFFF) begin
            od_nxt.error_code = ERR_OVF; ov_nxt = 1'b1; err_nxt = 1'b1;
          end else if (fill_r == '0 && !pf_r[2]) begin
            off_nxt = sum[15:0];
          end else if (count_r > 16'(MAX_FIELDS)) begin
            od_nxt.error_code = ERR_OVF; ov_nxt = 1'b1; err_nxt = 1'b1;
          end else if (count_r == 16'd0) begin
            fill_nxt = '0; pf_nxt = pf_r & 4'b0011; min_nxt = '0; max_nxt = '0;
          end else begin
            state_nxt = S_EMIT;
          end
        end
        S_EMIT: begin
          if (!ov_r || out_ready) begin
            ov_nxt = 1'b1;
            od_nxt.field_bit_offset = off_r;
            od_nxt.field_bit_size = sz_r;
            od_nxt.field_page = page_r;
            od_nxt.usage_id = (fill_r != '0) ? rd_r : rid;
            od_nxt.last = (17'(idx_r) + 17'd1 == {1'b0, count_r});
            od_nxt.error_code = ERR_OK;
            off_nxt = off_r + 16'(sz_r);
            idx_nxt = idx_r + 7'd1;
            if (od_nxt.last) begin
              state_nxt = S_IDLE;
              fill_nxt = '0; pf_nxt = pf_r & 4'b0011; min_nxt = '0; max_nxt = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0; sz_r <= '0; page_r <= '0; pf_r <= '0; fill_r <= '0;
      min_r <= '0; max_r <= '0; off_r <= '0; err_r <= 1'b0; idx_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt; sz_r <= sz_nxt; page_r <= page_nxt; pf_r <= pf_nxt;
      fill_r <= fill_nxt; min_r <= min_nxt; max_r <= max_nxt; off_r <= off_nxt;
      err_r <= err_nxt; idx_r <= idx_nxt; ov_r <= ov_nxt;
    end
    od_r <= od_nxt;
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_fill_max, clk, rst_n, 1'b1, fill_r <= FILL_W'(USAGE_DEPTH),
               "usage fill over depth")
  `ASSERT_IMPL(a_err_last, clk, rst_n, ov_r && od_r.error_code != ERR_OK, od_r.last,
               "error word without last")
  `ASSERT_IMPL(a_emit_count, clk, rst_n, state_r == S_EMIT, 17'(idx_r) < {1'b0, count_r},
               "field index past report count")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives descriptor bytes with random gaps and output stalls, predicts the
// field descriptors and error codes in a behavioral model, and compares them.
// ----------------------------------------------------------------------------
module tb import hidrd_pkg::*; ();

  localparam int WATCHDOG = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  hid_report_descriptor_parser_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // parser state mirror
  int unsigned pend_bytes, cur_tag, cur_size, accum;
  int unsigned rpt_count, rpt_size, page, flags, fill, umin, umax, offset;
  logic [15:0] usages [USAGE_DEPTH];
  bit          halted;

  out_word_t fields_q[$];
  int        errors, mismatches, bytes_sent, results_seen, idle_cycles;
  bit        done;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_state();
    pend_bytes = 0; cur_tag = 0; cur_size = 0; accum = 0;
    rpt_count = 0; rpt_size = 0; page = 0; flags = 0; fill = 0;
    umin = 0; umax = 0; offset = 0; halted = 0;
  endfunction

  function automatic void clear_local();
    fill = 0; flags &= 3; umin = 0; umax = 0;
  endfunction

  function automatic void push_error(logic [2:0] code);
    out_word_t w;
    w = '0;
    w.last = 1;
    w.error_code = code;
    halted = 1;
    fields_q.insert(fields_q.size(), w);
  endfunction

  function automatic void run_input();
    bit has_min, has_max;
    int unsigned total, id;
    out_word_t w;
    has_min = flags[2];
    has_max = flags[3];
    if (!flags[0] || !flags[1]) begin push_error(ERR_MISSING); return; end
    if (has_min != has_max) begin push_error(ERR_UNPAIR); return; end
    if (fill > 0 && has_min) begin push_error(ERR_BOTH); return; end
    total = rpt_size * rpt_count;
    if (offset + total > 32'hFFFF) begin push_error(ERR_OVF); return; end
    if (fill == 0 && !has_min) begin
      offset += total;
      return;
    end
    if (rpt_count > MAX_FIELDS) begin push_error(ERR_OVF); return; end
    for (int unsigned i = 0; i < rpt_count; i++) begin
      if (fill > 0) id = (i < fill) ? usages[i] : usages[fill-1];
      else begin
        id = (umin + i) & 16'hFFFF;
        if (id > umax) id = umax;
      end
      w.field_bit_offset = offset[15:0];
      w.field_bit_size = rpt_size[5:0];
      w.field_page = page[15:0];
      w.usage_id = id[15:0];
      w.last = (i + 1 == rpt_count);
      w.error_code = ERR_OK;
      fields_q.insert(fields_q.size(), w);
      offset += rpt_size;
    end
    clear_local();
  endfunction

  function automatic void run_item();
    logic [7:0] tag;
    tag = cur_tag[7:0];
    case (tag)
      TAG_END_COL, TAG_LMAX, TAG_LMIN: ;
      TAG_COL: clear_local();
      TAG_INPUT: run_input();
      TAG_COUNT: begin
        if (accum > 32'hFFFF) push_error(ERR_OVF);
        else begin rpt_count = accum; flags |= 1; end
      end
      TAG_SIZE: begin
        if (accum > 32) push_error(ERR_OVF);
        else begin rpt_size = accum; flags |= 2; end
      end
      TAG_PAGE: page = accum & 16'hFFFF;
      TAG_UMAX, TAG_UMIN, TAG_USAGE: begin
        if (cur_size >= 4) push_error(ERR_WIDE);
        else if (tag == TAG_UMAX) begin umax = accum & 16'hFFFF; flags |= 8; end
        else if (tag == TAG_UMIN) begin umin = accum & 16'hFFFF; flags |= 4; end
        else if (fill >= USAGE_DEPTH) push_error(ERR_FULL);
        else begin usages[fill] = accum[15:0]; fill++; end
      end
      default: push_error(ERR_TAG);
    endcase
  endfunction

  function automatic void predict_byte(in_word_t w);
    if (w.first) clear_state();
    if (halted) return;
    if (pend_bytes == 0) begin
      cur_tag = w.desc_byte & TAG_MASK;
      cur_size = (w.desc_byte[1:0] == 2'd3) ? 4 : w.desc_byte[1:0];
      accum = 0;
      if (cur_size == 0) run_item();
      else pend_bytes = cur_size;
      return;
    end
    accum |= int'(w.desc_byte) << (8 * ((cur_size - pend_bytes) & 3));
    pend_bytes--;
    if (pend_bytes == 0) run_item();
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(logic [7:0] b, bit first = 0);
    in_word_t w;
    int       gap;
    w.desc_byte = b;
    w.first = first;
    gap = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 16)) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(w);
    bytes_sent++;
    @(negedge clk);
  endtask

  // little-endian short item with chosen size code
  task automatic send_item(logic [7:0] tag, logic [1:0] code, logic [31:0] val,
                           bit first = 0);
    int n;
    n = (code == 3) ? 4 : code;
    send_byte(tag | code, first);
    for (int i = 0; i < n; i++) send_byte(val[8*i +: 8]);
  endtask

  function automatic logic [1:0] code_for(int unsigned v);
    if (v < 256) return 2'd1;
    if (v < 65536) return 2'd2;
    return 2'd3;
  endfunction

  task automatic send_value(logic [7:0] tag, int unsigned v, bit first = 0);
    send_item(tag, code_for(v), v, first);
  endtask

  task automatic test_directed();
    send_value(TAG_PAGE, 16'h0001, 1);
    send_item(TAG_END_COL, 0, 0);
    send_item(TAG_COL, 1, 1);
    send_value(TAG_SIZE, 1);
    send_value(TAG_COUNT, 3);
    send_value(TAG_USAGE, 16'hFFFF);
    send_value(TAG_USAGE, 16'h0002);
    send_item(TAG_INPUT, 1, 2);            // last usage repeats
    send_item(TAG_INPUT, 1, 2);            // padding
    send_item(TAG_LMIN, 2, 16'h8001);
    send_item(TAG_LMAX, 1, 8'h7F);
    send_item(TAG_PAGE, 3, 32'h1234_FF07); // wide page keeps low half
    send_value(TAG_SIZE, 32);
    send_value(TAG_COUNT, 4);
    send_item(TAG_UMIN, 2, 16'hFFFE);      // range wraps past 0xFFFF
    send_item(TAG_UMAX, 2, 16'hFFFF);
    send_item(TAG_INPUT, 1, 2);
    send_item(TAG_INPUT, 0, 0);            // padding
    send_value(TAG_COUNT, 0);
    send_value(TAG_USAGE, 5);
    send_item(TAG_INPUT, 0, 0);            // count zero with usages
    send_item(8'hF0, 2, 0);                // unknown tag, error then cleared by first
    send_item(TAG_INPUT, 0, 0, 1);         // missing size and count
    send_item(8'hFC, 3, 32'hFFFF_FFFF, 1); // unknown tag, all ones
  endtask

  task automatic test_errors();
    int k;
    for (int e = 0; e < 12; e++) begin
      send_value(TAG_SIZE, 8, 1);
      send_value(TAG_COUNT, 2);
      case (e)
        0: send_value(TAG_UMIN, 1);
        1: begin send_value(TAG_UMIN, 1); send_value(TAG_UMAX, 3); send_value(TAG_USAGE, 4); end
        2: send_value(TAG_COUNT, 32'h0001_0000);
        3: send_value(TAG_SIZE, 33);
        4: send_item(TAG_USAGE, 3, 7);
        5: send_item(TAG_UMIN, 3, 7);
        6: send_item(TAG_UMAX, 3, 7);
        7: for (k = 0; k < 17; k++) send_value(TAG_USAGE, k);
        8: begin send_value(TAG_COUNT, 65); send_value(TAG_USAGE, 1); end
        9: begin send_value(TAG_SIZE, 32); send_value(TAG_COUNT, 2100); end
        10: send_value(TAG_UMAX, 3);
        default: send_item(8'h30, 1, 0);
      endcase
      if (e == 8 || e == 0 || e == 1 || e == 10) send_item(TAG_INPUT, 1, 0);
      if (e == 9) send_item(TAG_INPUT, 1, 0);
      send_item(TAG_INPUT, 1, 0);  // ignored once latched
    end
  endtask

  task automatic test_random();
    int unsigned r, n, v;
    while (bytes_sent < 430) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else begin
        send_value(TAG_SIZE, $urandom_range(0, 32), r < 20);
        send_value(TAG_COUNT, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80)
                                                          : $urandom_range(0, 6));
        if ($urandom_range(0, 3) == 0) send_value(TAG_PAGE, $urandom);
        if ($urandom_range(0, 2) == 0) begin
          v = $urandom_range(0, 65535);
          send_item(TAG_UMIN, 2'($urandom_range(1, 2)), v);
          send_item(TAG_UMAX, 2'($urandom_range(1, 2)), v + $urandom_range(0, 4));
        end else begin
          n = $urandom_range(0, 5);
          for (int i = 0; i < n; i++)
            send_item(TAG_USAGE, 2'($urandom_range(1, 2)), $urandom);
        end
        if ($urandom_range(0, 7) == 0) send_item(TAG_COL, 1, 0);
        send_item(TAG_INPUT, 1, $urandom);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (fields_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected word %p", out_data);
      end else begin
        exp_w = fields_q[0];
        fields_q.delete(0);
        if (out_data !== exp_w) begin
          errors++;
          if (mismatches++ < 10) $display("mismatch: expected %p got %p", exp_w, out_data);
        end
      end
    end
  end

  // random output stalls
  initial begin
    int stall;
    out_ready = 0;
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0;
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG && !done) begin
      $display("hid_report_descriptor_parser_top test failed");
      $finish;
    end
  end

  initial begin
    rst_n = 0; in_valid = 0; in_data = '0;
    errors = 0; mismatches = 0; bytes_sent = 0; results_seen = 0; idle_cycles = 0;
    done = 0;
    clear_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_errors();
    test_random();
    in_valid <= 0;
    while (fields_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    done = 1;
    $display("sent %0d descriptor bytes, checked %0d result words", bytes_sent, results_seen);
    if (errors == 0 && fields_q.size() == 0)
      $display("hid_report_descriptor_parser_top test passed");
    else
      $display("hid_report_descriptor_parser_top test failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/hidrd_pkg.sv
design/hidrd_front.sv
design/hidrd_back.sv
design/hid_report_descriptor_parser_top.sv
test/tb.sv
